// ===== rtl/core/owm_pkg.sv =====
package owm_pkg;

  localparam int unsigned TickW = 12;
  localparam int unsigned LineMaskW = 3;
  localparam int unsigned LineSelW = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitNumW = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned InDataW = 16;
  localparam int unsigned InUserW = 2;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned LINE_COUNT_DEF = 3;
  localparam int unsigned READ_LOW_TICKS_DEF = 10;
  localparam int unsigned READ_RECOVERY_TICKS_DEF = 45;

  localparam logic [TickW-1:0] RESET_LOW_DEF = 12'd750;
  localparam logic [TickW-1:0] RESET_RELEASE_DEF = 12'd15;
  localparam logic [TickW-1:0] PRES_HIGH_DEF = 12'd100;
  localparam logic [TickW-1:0] PRES_LOW_DEF = 12'd240;
  localparam logic [TickW-1:0] ONE_LOW_DEF = 12'd8;
  localparam logic [TickW-1:0] ONE_HIGH_DEF = 12'd58;
  localparam logic [TickW-1:0] ZERO_LOW_DEF = 12'd70;
  localparam logic [TickW-1:0] ZERO_HIGH_DEF = 12'd2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_RESET_RELEASE = 3'd1,
    CFG_PRES_HIGH     = 3'd2,
    CFG_PRES_LOW      = 3'd3,
    CFG_ONE_LOW       = 3'd4,
    CFG_ONE_HIGH      = 3'd5,
    CFG_ZERO_LOW      = 3'd6,
    CFG_ZERO_HIGH     = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_REL    = 4'd2,
    PH_PRES_WAIT  = 4'd3,
    PH_PRES_PULSE = 4'd4,
    PH_WR_LOW     = 4'd5,
    PH_WR_HIGH    = 4'd6,
    PH_RD_LOW     = 4'd7,
    PH_RD_SAMPLE  = 4'd8,
    PH_RD_REC     = 4'd9
  } phase_t;

  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] d);
    logic [TickW-1:0] r;
    r = (d == '0) ? TickW'(1) : d;
    return r;
  endfunction

endpackage

// ===== rtl/core/one_wire_master_slots_core.sv =====
// 1-Wire bus master for up to three open-drain lines, time driven by tick items.
// input stream: in_tuser carries the action (tick, reset, write byte, read byte),
// in_tdata the line select, the byte to write and the sampled line level.
// every input transaction gives exactly one result transaction on out_: the
// line drive mask, busy, done, the byte read, presence failure and rejection.
// a command starts a job on its line; its own result already shows the line
// driven low. tick items step the running job; commands during a job are
// rejected and do not advance time.
// the result of each input transaction is held in the output register.
// throughput: one transaction per cycle if not stalled; the whole state update
// is one pass of logic between the accepted item and the state and result
// registers. the next item is taken in the same cycle the held result is taken,
// so a full output register only stalls the input while out_tready is low.
// timing registers are written through cfg_, one per cycle; the user must do so
// only while idle, the block does not check it. reset (rst_n low, synchronous):
// bus idle, counters cleared, output empty, timing registers back to defaults.
module one_wire_master_slots_core #(
  parameter int unsigned LINE_COUNT = owm_pkg::LINE_COUNT_DEF,
  parameter int unsigned READ_LOW_TICKS = owm_pkg::READ_LOW_TICKS_DEF,
  parameter int unsigned READ_RECOVERY_TICKS = owm_pkg::READ_RECOVERY_TICKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // line_select [1:0], write_data [9:2], line_level [10]
  input  logic [owm_pkg::InDataW-1:0]    in_tdata,
  // action [1:0]
  input  logic [owm_pkg::InUserW-1:0]    in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // drive_low_mask [2:0], busy_res [3], done_res [4], read_data [12:5],
  // presence_fail [13], rejected [14]
  output logic [owm_pkg::OutDataW-1:0]   out_tdata,
  input  logic                           cfg_we,
  input  logic [owm_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [owm_pkg::TickW-1:0]      cfg_wdata
);
  import owm_pkg::*;

  localparam logic [TickW-1:0] RdLowTicks = TickW'(READ_LOW_TICKS);
  localparam logic [TickW-1:0] RdRecTicks = TickW'(READ_RECOVERY_TICKS);

  logic [TickW-1:0] reset_low_r, reset_release_r, pres_high_r, pres_low_r;
  logic [TickW-1:0] one_low_r, one_high_r, zero_low_r, zero_high_r;

  phase_t             phase_r, phase_nxt;
  logic [TickW-1:0]   tick_count_r, tick_count_nxt;
  logic [BitNumW-1:0] bit_number_r, bit_number_nxt;
  logic [ByteW-1:0]   shift_byte_r, shift_byte_nxt;
  logic [LineSelW-1:0] active_line_r, active_line_nxt;
  action_t            cur_cmd_r, cur_cmd_nxt;

  logic                  out_valid_r;
  logic [OutDataW-1:0]   out_data_r, out_data_nxt;

  action_t             act;
  logic [LineSelW-1:0] sel;
  logic [ByteW-1:0]    wdata;
  logic                level;
  logic                accept;
  logic [TickW-1:0]    tc_inc;
  logic                done_nxt, pfail_nxt, rej_nxt, finish;
  logic [ByteW-1:0]    rdata_nxt;
  logic [LineMaskW-1:0] drive_nxt;

  assign act    = action_t'(in_tuser);
  assign sel    = in_tdata[1:0];
  assign wdata  = in_tdata[9:2];
  assign level  = in_tdata[10];
  assign in_tready = !out_valid_r || out_tready;
  assign accept = in_tvalid && in_tready;
  assign tc_inc = tick_count_r + TickW'(1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= RESET_LOW_DEF;
      reset_release_r <= RESET_RELEASE_DEF;
      pres_high_r     <= PRES_HIGH_DEF;
      pres_low_r      <= PRES_LOW_DEF;
      one_low_r       <= ONE_LOW_DEF;
      one_high_r      <= ONE_HIGH_DEF;
      zero_low_r      <= ZERO_LOW_DEF;
      zero_high_r     <= ZERO_HIGH_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RESET_LOW:     reset_low_r     <= cfg_wdata;
        CFG_RESET_RELEASE: reset_release_r <= cfg_wdata;
        CFG_PRES_HIGH:     pres_high_r     <= cfg_wdata;
        CFG_PRES_LOW:      pres_low_r      <= cfg_wdata;
        CFG_ONE_LOW:       one_low_r       <= cfg_wdata;
        CFG_ONE_HIGH:      one_high_r      <= cfg_wdata;
        CFG_ZERO_LOW:      zero_low_r      <= cfg_wdata;
        CFG_ZERO_HIGH:     zero_high_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    bit_number_nxt  = bit_number_r;
    shift_byte_nxt  = shift_byte_r;
    active_line_nxt = active_line_r;
    cur_cmd_nxt     = cur_cmd_r;
    done_nxt        = 1'b0;
    pfail_nxt       = 1'b0;
    rej_nxt         = 1'b0;
    rdata_nxt       = '0;
    finish          = 1'b0;
    if (act != ACT_TICK) begin
      if (phase_r != PH_IDLE || 32'(sel) >= LINE_COUNT) begin
        rej_nxt = 1'b1;
      end else begin
        active_line_nxt = sel;
        cur_cmd_nxt     = act;
        bit_number_nxt  = '0;
        tick_count_nxt  = '0;
        shift_byte_nxt  = '0;
        unique case (act)
          ACT_RESET: phase_nxt = PH_RST_LOW;
          ACT_WRITE: begin
            phase_nxt      = PH_WR_LOW;
            shift_byte_nxt = wdata;
          end
          default:   phase_nxt = PH_RD_LOW;
        endcase
      end
    end else begin
      tick_count_nxt = tc_inc;
      unique case (phase_r)
        PH_IDLE: tick_count_nxt = tick_count_r;
        PH_RST_LOW: begin
          if (tc_inc >= at_least_one(reset_low_r)) begin
            phase_nxt = PH_RST_REL;
            tick_count_nxt = '0;
          end
        end
        PH_RST_REL: begin
          if (tc_inc >= at_least_one(reset_release_r)) begin
            phase_nxt = PH_PRES_WAIT;
            tick_count_nxt = '0;
          end
        end
        PH_PRES_WAIT: begin
          if (level) begin
            if (tc_inc >= at_least_one(pres_high_r)) begin
              pfail_nxt = 1'b1;
              finish    = 1'b1;
            end
          end else begin
            phase_nxt      = PH_PRES_PULSE;
            tick_count_nxt = TickW'(1);
            if (TickW'(1) >= at_least_one(pres_low_r)) begin
              pfail_nxt = 1'b1;
              finish    = 1'b1;
            end
          end
        end
        PH_PRES_PULSE: begin
          if (!level) begin
            if (tc_inc >= at_least_one(pres_low_r)) begin
              pfail_nxt = 1'b1;
              finish    = 1'b1;
            end
          end else begin
            finish = 1'b1;
          end
        end
        PH_WR_LOW: begin
          if (tc_inc >= at_least_one(shift_byte_r[0] ? one_low_r : zero_low_r)) begin
            phase_nxt = PH_WR_HIGH;
            tick_count_nxt = '0;
          end
        end
        PH_WR_HIGH: begin
          if (tc_inc >= at_least_one(shift_byte_r[0] ? one_high_r : zero_high_r)) begin
            shift_byte_nxt = shift_byte_r >> 1;
            if (bit_number_r == BitNumW'(7)) begin
              finish = 1'b1;
            end else begin
              bit_number_nxt = bit_number_r + BitNumW'(1);
              phase_nxt      = PH_WR_LOW;
              tick_count_nxt = '0;
            end
          end
        end
        PH_RD_LOW: begin
          if (tc_inc >= at_least_one(RdLowTicks)) begin
            phase_nxt = PH_RD_SAMPLE;
            tick_count_nxt = '0;
          end
        end
        PH_RD_SAMPLE: begin
          shift_byte_nxt = {level, shift_byte_r[ByteW-1:1]};
          phase_nxt      = PH_RD_REC;
          tick_count_nxt = '0;
        end
        PH_RD_REC: begin
          if (tc_inc >= at_least_one(RdRecTicks)) begin
            if (bit_number_r == BitNumW'(7)) begin
              rdata_nxt = shift_byte_r;
              finish    = 1'b1;
            end else begin
              bit_number_nxt = bit_number_r + BitNumW'(1);
              phase_nxt      = PH_RD_LOW;
              tick_count_nxt = '0;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (finish) begin
        done_nxt       = 1'b1;
        phase_nxt      = PH_IDLE;
        tick_count_nxt = '0;
      end
    end
  end

  // result
  always_comb begin
    drive_nxt = '0;
    if (phase_nxt == PH_RST_LOW || phase_nxt == PH_WR_LOW || phase_nxt == PH_RD_LOW) begin
      drive_nxt = LineMaskW'(1) << active_line_nxt;
    end
    out_data_nxt = {1'b0, rej_nxt, pfail_nxt, rdata_nxt, done_nxt,
                    (phase_nxt != PH_IDLE), drive_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      bit_number_r  <= '0;
      shift_byte_r  <= '0;
      active_line_r <= '0;
      cur_cmd_r     <= ACT_TICK;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        tick_count_r  <= tick_count_nxt;
        bit_number_r  <= bit_number_nxt;
        shift_byte_r  <= shift_byte_nxt;
        active_line_r <= active_line_nxt;
        cur_cmd_r     <= cur_cmd_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
